// File: rtl/bfc_pkg.sv
// bfc_pkg: sizes, widths and state encoding for the budget fit counter
// no dependencies; imported by the interfaces and the top level
package bfc_pkg;
  localparam int MAX_ITEMS = 1024;
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = 31;
  localparam int SW = PW + CW;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ICMP = 6'b000010,
    ST_IWR  = 6'b000100,
    ST_SRD  = 6'b001000,
    ST_SCMP = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;
endpackage

// File: rtl/bfc_if.sv
// bfc_in_if / bfc_out_if: valid-ready channels for prices and results
// depends on bfc_pkg for field widths
interface bfc_in_if import bfc_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] item_price;
  logic          is_last;
  modport source (output valid, item_price, is_last, input ready);
  modport sink   (input valid, item_price, is_last, output ready);
endinterface

interface bfc_out_if import bfc_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] fit_count;
  logic          store_full;
  modport source (output valid, fit_count, store_full, input ready);
  modport sink   (input valid, fit_count, store_full, output ready);
endinterface

// File: rtl/budget_fit_count_smallest_unit.sv
// budget_fit_count_smallest_unit: sorted price store and budget fit counter
// depends on bfc_pkg and the channel interfaces in bfc_if.sv
//
// channel  | direction | payload
// in_ch    | sink      | item_price, is_last
// out_ch   | source    | fit_count, store_full
// cfg      | write     | cfg_wdata (budget)
//
// each price is insertion-sorted into a one-port-read, one-port-write ram as it
// arrives, each larger stored price shifting up one place; an empty store takes it
// directly, a full store drops it and sets the flag. a closing transaction then
// scans the ram from the smallest price until the total passes the budget or all
// stored prices fit. reset clears the control registers; the ram needs no clearing.
// a waiting result holds the unit in its final state until out_ch takes it.
module budget_fit_count_smallest_unit import bfc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [PW-1:0] cfg_wdata,
  bfc_in_if.sink        in_ch,
  bfc_out_if.source     out_ch
);
  logic [PW-1:0] mem [MAX_ITEMS];
  logic [PW-1:0] rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] wr_data;

  state_t        state_r, state_nxt;
  logic [PW-1:0] budget_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          flag_r, flag_nxt;
  logic [PW-1:0] val_r, val_nxt;
  logic          last_r, last_nxt;
  logic [AW-1:0] hole_r, hole_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] total_r, total_nxt;
  logic [CW-1:0] fit_r, fit_nxt;
  logic          out_valid_r;
  logic [CW-1:0] out_fit_r;
  logic          out_full_r;
  logic [SW-1:0] sum;
  logic          accept;
  logic          fin_go;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign accept            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.fit_count  = out_fit_r;
  assign out_ch.store_full = out_full_r;
  assign sum    = total_r + {{CW{1'b0}}, rd_data_r};
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // price ram, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // insertion and scan sequencing
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    flag_nxt  = flag_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    hole_nxt  = hole_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    fit_nxt   = fit_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = val_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt  = in_ch.item_price;
          last_nxt = in_ch.is_last;
          if (count_r == CW'(MAX_ITEMS)) begin
            flag_nxt  = 1'b1;
            state_nxt = in_ch.is_last ? ST_SRD : ST_IDLE;
          end else if (count_r == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = in_ch.item_price;
            count_nxt = count_r + 1'b1;
            state_nxt = in_ch.is_last ? ST_SRD : ST_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = AW'(count_r - 1'b1);
            hole_nxt  = AW'(count_r);
            state_nxt = ST_ICMP;
          end
        end
      end
      ST_ICMP: begin
        wr_en   = 1'b1;
        wr_addr = hole_r;
        if (rd_data_r > val_r) begin
          // shift the larger price up one place
          wr_data  = rd_data_r;
          hole_nxt = hole_r - 1'b1;
          if (hole_r == AW'(1)) begin
            state_nxt = ST_IWR;
          end else begin
            rd_en   = 1'b1;
            rd_addr = hole_r - AW'(2);
          end
        end else begin
          wr_data   = val_r;
          count_nxt = count_r + 1'b1;
          state_nxt = last_r ? ST_SRD : ST_IDLE;
        end
      end
      ST_IWR: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = val_r;
        count_nxt = count_r + 1'b1;
        state_nxt = last_r ? ST_SRD : ST_IDLE;
      end
      ST_SRD: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        idx_nxt   = '0;
        total_nxt = '0;
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        // running total against the budget
        if (sum > {{CW{1'b0}}, budget_r}) begin
          fit_nxt   = idx_r;
          state_nxt = ST_FIN;
        end else if (idx_r + 1'b1 == count_r) begin
          fit_nxt   = count_r;
          state_nxt = ST_FIN;
        end else begin
          total_nxt = sum;
          idx_nxt   = idx_r + 1'b1;
          rd_en     = 1'b1;
          rd_addr   = AW'(idx_r + 1'b1);
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          count_nxt = '0;
          flag_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      budget_r    <= '0;
      count_r     <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    last_r  <= last_nxt;
    hole_r  <= hole_nxt;
    idx_r   <= idx_nxt;
    total_r <= total_nxt;
    fit_r   <= fit_nxt;
    if (fin_go) begin
      out_fit_r  <= fit_r;
      out_full_r <= flag_r;
    end
  end
endmodule

// File: sim/bfc_tb_if.sv
// bfc_tb_types: packed transaction structs used by the bench
// depends on bfc_pkg for field widths
package bfc_tb_types;
  import bfc_pkg::*;
  typedef struct packed {
    logic [PW-1:0] item_price;
    logic          is_last;
  } price_txn_t;
  typedef struct packed {
    logic [CW-1:0] fit_count;
    logic          store_full;
  } fit_txn_t;
endpackage

// File: sim/tb_top.sv
// tb_top: self-checking bench for budget_fit_count_smallest_unit
// drives price sets over in_ch, predicts each fit count and compares out_ch
// depends on bfc_pkg, bfc_if.sv and bfc_tb_types
module tb_top;
  import bfc_pkg::*;
  import bfc_tb_types::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [PW-1:0] cfg_wdata = '0;

  bfc_in_if  in_ch ();
  bfc_out_if out_ch ();

  budget_fit_count_smallest_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [PW-1:0] budget_reg;
  logic [PW-1:0] set_prices [$];
  logic          set_dropped;
  fit_txn_t      expected_fits [$];
  price_txn_t    pending_prices [$];

  int error_count = 0;
  int sets_sent = 0;
  int prices_sent = 0;
  int fits_seen = 0;
  longint cycle_count = 0;
  bit stall_long = 1'b0;
  bit hold_sender = 1'b0;

  // fit count of the smallest prices within the budget
  function automatic fit_txn_t predict_fit();
    logic [PW-1:0] sorted [$];
    logic [63:0] total;
    fit_txn_t r;
    sorted = set_prices;
    sorted.sort();
    total = '0;
    r.fit_count = '0;
    foreach (sorted[i]) begin
      if (total + sorted[i] > {33'd0, budget_reg}) break;
      total += sorted[i];
      r.fit_count++;
    end
    r.store_full = set_dropped;
    return r;
  endfunction

  // account one accepted price
  function automatic void absorb_price(price_txn_t t);
    if (set_prices.size() < MAX_ITEMS) set_prices = {set_prices, t.item_price};
    else set_dropped = 1'b1;
    if (t.is_last) begin
      expected_fits = {expected_fits, predict_fit()};
      set_prices.delete();
      set_dropped = 1'b0;
    end
  endfunction

  function automatic logic [PW-1:0] rand_price(int mode);
    case (mode)
      0: return PW'($urandom_range(0, 20));
      1: return PW'($urandom_range(0, 1000));
      2: return PW'($urandom) & {PW{1'b1}};
      default: return {PW{1'b1}} - PW'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic queue_set(int n, int mode);
    price_txn_t t;
    for (int i = 0; i < n; i++) begin
      t.item_price = rand_price(mode);
      t.is_last = (i == n - 1);
      pending_prices = {pending_prices, t};
    end
  endtask

  task automatic queue_one(logic [PW-1:0] p, logic last);
    price_txn_t t;
    t.item_price = p;
    t.is_last = last;
    pending_prices = {pending_prices, t};
  endtask

  // wait until every queued price is taken and every fit count has come
  task automatic drain();
    while (pending_prices.size() != 0 || in_ch.valid || expected_fits.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_budget(logic [PW-1:0] b);
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    budget_reg = b;
    @(posedge clk);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver: offers queued prices with random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.item_price <= '0;
      in_ch.is_last <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_price('{item_price: in_ch.item_price, is_last: in_ch.is_last});
        prices_sent++;
        if (in_ch.is_last) sets_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_prices.size() != 0 && !hold_sender) begin
          price_txn_t t;
          t = pending_prices.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.item_price <= t.item_price;
          in_ch.is_last <= t.is_last;
          in_gap = gap_len();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side stalls
  int out_gap = 0;
  always @(posedge clk) begin
    fit_txn_t want;
    cycle_count++;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        fits_seen++;
        if (expected_fits.size() == 0) begin
          $display("%0t unexpected result: fit_count %0d store_full %0b", $time,
                   out_ch.fit_count, out_ch.store_full);
          error_count++;
        end else begin
          want = expected_fits.pop_front();
          if (want.fit_count !== out_ch.fit_count) begin
            $display("%0t fit_count mismatch: expected %0d actual %0d", $time,
                     want.fit_count, out_ch.fit_count);
            error_count++;
          end
          if (want.store_full !== out_ch.store_full) begin
            $display("%0t store_full mismatch: expected %0b actual %0b", $time,
                     want.store_full, out_ch.store_full);
            error_count++;
          end
        end
      end
      if (stall_long) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap = gap_len();
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycle_count > 3000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // long receiver hold-off, counted here while the sender keeps offering
  task automatic long_stall(int cycles);
    stall_long = 1'b1;
    repeat (cycles) @(posedge clk);
    stall_long = 1'b0;
  endtask

  initial begin
    int mode;
    int n;
    budget_reg = '0;
    set_dropped = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset budget of zero: only zero prices fit
    queue_one('0, 1'b1);
    queue_one('0, 1'b0);
    queue_one(PW'(5), 1'b1);
    drain();

    // extreme budget with extreme prices, single and multi
    set_budget({PW{1'b1}});
    queue_one({PW{1'b1}}, 1'b1);
    queue_one({PW{1'b1}}, 1'b0);
    queue_one({PW{1'b1}}, 1'b0);
    queue_one('0, 1'b1);
    queue_one(PW'(1), 1'b0);
    queue_one({PW{1'b1}} - 1, 1'b1);
    queue_one(PW'(30), 1'b0);
    queue_one(PW'(10), 1'b0);
    queue_one(PW'(20), 1'b0);
    queue_one(PW'(10), 1'b1);
    drain();

    // budget exactly on a running total
    set_budget(PW'(40));
    queue_one(PW'(30), 1'b0);
    queue_one(PW'(10), 1'b0);
    queue_one(PW'(20), 1'b0);
    queue_one(PW'(10), 1'b1);
    queue_one(PW'(41), 1'b1);
    queue_one(PW'(40), 1'b1);
    drain();

    // receiver held off for a long stretch while sets keep coming
    set_budget(PW'(100));
    for (int i = 0; i < 6; i++) queue_set($urandom_range(1, 4), 0);
    long_stall(400);
    drain();

    // random phases over several budgets
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_budget('0);
        1: set_budget(PW'($urandom_range(0, 200)));
        2: set_budget(PW'($urandom_range(0, 20000)));
        3: set_budget(PW'($urandom) & {PW{1'b1}});
        4: set_budget({PW{1'b1}});
        default: set_budget({1'b1, {(PW-1){1'b0}}});
      endcase
      for (int s = 0; s < 10; s++) begin
        mode = $urandom_range(0, 3);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        queue_set(n, mode);
      end
      // sender pauses mid-stream until every expected result is in
      if (phase == 2) begin
        while (pending_prices.size() > 20) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_fits.size() != 0 || in_ch.valid) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    drain();
    repeat (MAX_ITEMS * 2 + 50) @(posedge clk);
    $display("run covered %0d prices in %0d sets, %0d fit counts checked",
             prices_sent, sets_sent, fits_seen);
    $display("budgets from zero to full range, sender pauses and long receiver stalls");
    if (error_count == 0 && expected_fits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (expected_fits.size() != 0)
        $display("%0t %0d fit counts never arrived", $time, expected_fits.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
